@@ sv/clcd_pkg.sv @@
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared codes and helpers for the character LCD controller: pin levels,
// status and action codes, command bytes and character constants.
// ----------------------------------------------------------------------------
package clcd_pkg;

   typedef logic [1:0] level_type;
   typedef logic [2:0] status_type;
   typedef logic [1:0] action_type;

   // pin levels
   localparam level_type LEVEL_LOW   = 2'd0;
   localparam level_type LEVEL_HIGH  = 2'd1;
   localparam level_type LEVEL_UNDEF = 2'd2;

   // status codes
   localparam status_type STATUS_OK         = 3'd0;
   localparam status_type STATUS_EN_UNDEF   = 3'd1;
   localparam status_type STATUS_CTRL_UNDEF = 3'd2;
   localparam status_type STATUS_READ       = 3'd3;
   localparam status_type STATUS_DATA_UNDEF = 3'd4;

   // action codes
   localparam action_type ACTION_NONE  = 2'd0;
   localparam action_type ACTION_CMD   = 2'd1;
   localparam action_type ACTION_WRITE = 2'd2;

   // command bytes and masks
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;
   localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
   localparam logic [7:0] ADDR_MASK      = 8'h7F;
   localparam logic [7:0] DISP_MASK      = 8'hF8;
   localparam logic [7:0] CMD_DISPLAY    = 8'h08;
   localparam logic [7:0] DISP_ON_BIT    = 8'h04;
   localparam logic [7:0] ENTRY_MASK     = 8'hFC;
   localparam logic [7:0] CMD_ENTRY      = 8'h04;
   localparam logic [7:0] ENTRY_INC_BIT  = 8'h02;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // cursor addressing
   localparam logic signed [8:0] CURSOR_MIN   = -9'sd128;
   localparam logic signed [8:0] CURSOR_MAX   = 9'sd255;
   localparam logic signed [9:0] ROW_TWO_BASE = 10'sd64;

   // level code three reads as undefined
   function automatic level_type level_norm(input logic [1:0] raw);
      level_type lvl;
      lvl = (raw > LEVEL_UNDEF) ? LEVEL_UNDEF : raw;
      return lvl;
   endfunction

endpackage

@@ sv/character_lcd_controller.sv @@
// ----------------------------------------------------------------------------
// character_lcd_controller
// Two-row character LCD model with an HD44780-style write port.
//
// Each request carries one sample of the LCD pins (E, RS, RW, data bus,
// data-defined flag) plus a cell index to read back. Writes act on a
// low-to-high edge of E: RS low runs a command, RS high stores a character
// at the cursor and steps the cursor. Every request yields one response with
// status, action, cursor, mode bits and the character at the chosen cell.
//
// Both channels use valid/ready. A request is held in an input register and
// processed into the response register once that register is empty or being
// read; throughput is one request per cycle while the response side is not
// stalled. The input register refills in the same cycle it drains, so a
// waiting response does not block the next request until both stages fill.
// A stalled response simply holds its register and the input stage behind it.
// Reset is synchronous: store reads as all spaces, cursor zero, display on,
// increment mode, E level undefined; both stages empty. The clear command
// blanks the whole store by clearing the per-cell valid bits.
// ----------------------------------------------------------------------------
module character_lcd_controller
   import clcd_pkg::*;
#(
   parameter int COLUMNS = 16
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_enable_level,
   input  logic [1:0]        req_select_level,
   input  logic [1:0]        req_direction_level,
   input  logic [7:0]        req_bus_byte,
   input  logic              req_bus_defined,
   input  logic [4:0]        req_view_index,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [1:0]        rsp_action,
   output logic signed [8:0] rsp_cursor,
   output logic              rsp_shown,
   output logic              rsp_count_up,
   output logic [7:0]        rsp_view_char
);

   localparam int unsigned CELLS = 2 * COLUMNS;
   localparam int IDX_W = $clog2(CELLS);
   localparam logic signed [9:0] COL_LIM = 10'(COLUMNS);

   // input stage
   logic              s1_vld_ff;
   logic [1:0]        s1_enable_ff;
   logic [1:0]        s1_select_ff;
   logic [1:0]        s1_direction_ff;
   logic [7:0]        s1_data_ff;
   logic              s1_defined_ff;
   logic [IDX_W-1:0]  s1_view_addr_ff;
   logic              s1_in_range_ff;
   logic [7:0]        rd_raw_ff;
   logic              rd_vld_ff;
   logic              byp_ff;
   logic [7:0]        byp_char_ff;

   // block state
   logic [7:0]        store_mem [CELLS];
   logic [CELLS-1:0]  cell_vld_ff;
   logic signed [8:0] cursor_ff;
   logic              shown_ff;
   logic              inc_ff;
   level_type         last_en_ff;

   // response register
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   action_type        rsp_action_ff;
   logic signed [8:0] rsp_cursor_ff;
   logic              rsp_shown_ff;
   logic              rsp_count_up_ff;
   logic [7:0]        rsp_view_char_ff;

   logic              req_accept;
   logic              fire;
   logic [IDX_W-1:0]  req_view_addr;
   logic              req_in_range;

   level_type         en;
   level_type         rs;
   level_type         rw;
   logic              rising;
   logic              cmd_go;
   logic              char_go;
   status_type        status_in;
   action_type        action_in;
   logic signed [8:0] cursor_in;
   logic              shown_in;
   logic              inc_in;
   logic              do_clear;
   logic              row_two;
   logic signed [9:0] col;
   logic              col_hit;
   logic [IDX_W-1:0]  wr_idx;
   logic              mem_we;
   logic              own_hit;
   logic [7:0]        stored_char;
   logic [7:0]        cell_char;
   logic [7:0]        view_char_in;

   assign fire       = s1_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_vld_ff || fire;
   assign req_accept = req_valid && req_ready;

   assign req_view_addr = IDX_W'(req_view_index);
   assign req_in_range  = 32'(req_view_index) < CELLS;

   // decode of the pin sample held in the input stage
   always_comb begin
      en = level_norm(s1_enable_ff);
      rs = level_norm(s1_select_ff);
      rw = level_norm(s1_direction_ff);
      rising = (last_en_ff == LEVEL_LOW) && (en == LEVEL_HIGH);

      status_in = STATUS_OK;
      action_in = ACTION_NONE;
      cmd_go    = 1'b0;
      char_go   = 1'b0;
      if (en == LEVEL_UNDEF) begin
         status_in = STATUS_EN_UNDEF;
      end else if (rising) begin
         if (rs == LEVEL_UNDEF || rw == LEVEL_UNDEF) begin
            status_in = STATUS_CTRL_UNDEF;
         end else if (rw == LEVEL_HIGH) begin
            status_in = STATUS_READ;
         end else if (!s1_defined_ff) begin
            status_in = STATUS_DATA_UNDEF;
         end else if (rs == LEVEL_LOW) begin
            cmd_go    = 1'b1;
            action_in = ACTION_CMD;
         end else begin
            char_go   = 1'b1;
            action_in = ACTION_WRITE;
         end
      end
   end

   // cursor cell: row two begins at address 0x40
   always_comb begin
      row_two = 10'(cursor_ff) >= ROW_TWO_BASE;
      col     = row_two ? (10'(cursor_ff) - ROW_TWO_BASE) : 10'(cursor_ff);
      col_hit = (col >= 10'sd0) && (col < COL_LIM);
      wr_idx  = row_two ? (IDX_W'(col) + IDX_W'(COLUMNS)) : IDX_W'(col);
   end

   // commands and cursor stepping
   always_comb begin
      cursor_in = cursor_ff;
      shown_in  = shown_ff;
      inc_in    = inc_ff;
      do_clear  = 1'b0;
      if (cmd_go) begin
         if (s1_data_ff == CMD_CLEAR) begin
            do_clear  = 1'b1;
            cursor_in = '0;
         end else if (s1_data_ff == CMD_HOME) begin
            cursor_in = '0;
         end else if ((s1_data_ff & CMD_SET_ADDR) != 8'h00) begin
            cursor_in = 9'(s1_data_ff & ADDR_MASK);
         end else if ((s1_data_ff & DISP_MASK) == CMD_DISPLAY) begin
            shown_in = (s1_data_ff & DISP_ON_BIT) != 8'h00;
         end else if ((s1_data_ff & ENTRY_MASK) == CMD_ENTRY) begin
            inc_in = (s1_data_ff & ENTRY_INC_BIT) != 8'h00;
         end
      end else if (char_go) begin
         if (inc_ff) begin
            if (cursor_ff < CURSOR_MAX) cursor_in = cursor_ff + 9'sd1;
         end else begin
            if (cursor_ff > CURSOR_MIN) cursor_in = cursor_ff - 9'sd1;
         end
      end
   end

   assign mem_we = fire && char_go && col_hit;

   // read back the view cell as it stands after this request
   always_comb begin
      own_hit     = char_go && col_hit && (wr_idx == s1_view_addr_ff);
      stored_char = byp_ff ? byp_char_ff : (rd_vld_ff ? rd_raw_ff : SPACE_CHAR);
      cell_char   = own_hit ? s1_data_ff : (do_clear ? SPACE_CHAR : stored_char);
      view_char_in = (shown_in && s1_in_range_ff) ? cell_char : SPACE_CHAR;
   end

   // character store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_idx] <= s1_data_ff;
      end
      if (req_accept) begin
         rd_raw_ff <= store_mem[req_view_addr];
      end
   end

   // input stage payload; forward the write of the request draining now
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_enable_ff    <= req_enable_level;
         s1_select_ff    <= req_select_level;
         s1_direction_ff <= req_direction_level;
         s1_data_ff      <= req_bus_byte;
         s1_defined_ff   <= req_bus_defined;
         s1_view_addr_ff <= req_view_addr;
         s1_in_range_ff  <= req_in_range;
         rd_vld_ff       <= req_in_range && cell_vld_ff[req_view_addr]
                            && !(fire && do_clear);
         byp_ff          <= mem_we && (wr_idx == req_view_addr);
         byp_char_ff     <= s1_data_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         cell_vld_ff <= '0;
         cursor_ff   <= '0;
         shown_ff    <= 1'b1;
         inc_ff      <= 1'b1;
         last_en_ff  <= LEVEL_UNDEF;
      end else begin
         if (req_accept) begin
            s1_vld_ff <= 1'b1;
         end else if (fire) begin
            s1_vld_ff <= 1'b0;
         end
         if (fire) begin
            cursor_ff  <= cursor_in;
            shown_ff   <= shown_in;
            inc_ff     <= inc_in;
            last_en_ff <= en;
            if (do_clear) begin
               cell_vld_ff <= '0;
            end else if (mem_we) begin
               cell_vld_ff[wr_idx] <= 1'b1;
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff    <= status_in;
         rsp_action_ff    <= action_in;
         rsp_cursor_ff    <= cursor_in;
         rsp_shown_ff     <= shown_in;
         rsp_count_up_ff  <= inc_in;
         rsp_view_char_ff <= view_char_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_action    = rsp_action_ff;
   assign rsp_cursor    = rsp_cursor_ff;
   assign rsp_shown     = rsp_shown_ff;
   assign rsp_count_up  = rsp_count_up_ff;
   assign rsp_view_char = rsp_view_char_ff;

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_action_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_action == ACTION_NONE || rsp_status == STATUS_OK))
      else $error("action taken with a bad status");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor >= CURSOR_MIN))
      else $error("cursor below its lower limit");

   a_blank_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_shown) |-> (rsp_view_char == SPACE_CHAR))
      else $error("character shown while display is off");

   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed request produced no response");

endmodule

@@ test/character_lcd_checker.sv @@
// ----------------------------------------------------------------------------
// character_lcd_checker
// Watches both channels of the character LCD controller, predicts every
// response from the accepted requests and compares it field by field.
// ----------------------------------------------------------------------------
module character_lcd_checker
   import clcd_pkg::*;
#(
   parameter int COLUMNS = 16
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_enable_level,
   input  logic [1:0]        req_select_level,
   input  logic [1:0]        req_direction_level,
   input  logic [7:0]        req_bus_byte,
   input  logic              req_bus_defined,
   input  logic [4:0]        req_view_index,

   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [2:0]        rsp_status,
   input  logic [1:0]        rsp_action,
   input  logic signed [8:0] rsp_cursor,
   input  logic              rsp_shown,
   input  logic              rsp_count_up,
   input  logic [7:0]        rsp_view_char,

   output int                fail_count,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELLS = 2 * COLUMNS;

   typedef struct packed {
      status_type status;
      action_type action;
      logic [8:0] cursor;
      logic       shown;
      logic       count_up;
      logic [7:0] view_char;
   } lcd_result_type;

   // shadow of the display state
   logic [7:0]  cell_text [CELLS];
   int          cursor_pos;
   logic        display_on;
   logic        count_up_mode;
   level_type   prior_enable;

   lcd_result_type expected_rsp [$];

   function automatic void blank_cells();
      foreach (cell_text[i]) cell_text[i] = SPACE_CHAR;
   endfunction

   function automatic lcd_result_type lcd_step(input logic [1:0] en_raw, rs_raw, rw_raw,
                                               input logic [7:0] data, input logic data_ok,
                                               input logic [4:0] view);
      level_type      en;
      level_type      rs;
      level_type      rw;
      int             row;
      int             col;
      lcd_result_type res;
      en = (en_raw > LEVEL_UNDEF) ? LEVEL_UNDEF : en_raw;
      rs = (rs_raw > LEVEL_UNDEF) ? LEVEL_UNDEF : rs_raw;
      rw = (rw_raw > LEVEL_UNDEF) ? LEVEL_UNDEF : rw_raw;
      res.status = STATUS_OK;
      res.action = ACTION_NONE;
      if (en == LEVEL_UNDEF) begin
         res.status   = STATUS_EN_UNDEF;
         prior_enable = LEVEL_UNDEF;
      end else begin
         if (prior_enable == LEVEL_LOW && en == LEVEL_HIGH) begin
            if (rs == LEVEL_UNDEF || rw == LEVEL_UNDEF) begin
               res.status = STATUS_CTRL_UNDEF;
            end else if (rw == LEVEL_HIGH) begin
               res.status = STATUS_READ;
            end else if (!data_ok) begin
               res.status = STATUS_DATA_UNDEF;
            end else if (rs == LEVEL_LOW) begin
               res.action = ACTION_CMD;
               if (data == CMD_CLEAR) begin
                  blank_cells();
                  cursor_pos = 0;
               end else if (data == CMD_HOME) begin
                  cursor_pos = 0;
               end else if ((data & CMD_SET_ADDR) != 0) begin
                  cursor_pos = int'(data & ADDR_MASK);
               end else if ((data & DISP_MASK) == CMD_DISPLAY) begin
                  display_on = (data & DISP_ON_BIT) != 0;
               end else if ((data & ENTRY_MASK) == CMD_ENTRY) begin
                  count_up_mode = (data & ENTRY_INC_BIT) != 0;
               end
            end else begin
               res.action = ACTION_WRITE;
               row = 0;
               col = cursor_pos;
               if (cursor_pos >= ROW_TWO_BASE) begin
                  row = 1;
                  col = cursor_pos - ROW_TWO_BASE;
               end
               // drop characters that land outside both rows
               if (col >= 0 && col < COLUMNS) cell_text[row * COLUMNS + col] = data;
               if (count_up_mode) begin
                  if (cursor_pos < CURSOR_MAX) cursor_pos++;
               end else begin
                  if (cursor_pos > CURSOR_MIN) cursor_pos--;
               end
            end
         end
         prior_enable = en;
      end
      res.cursor    = cursor_pos[8:0];
      res.shown     = display_on;
      res.count_up  = count_up_mode;
      res.view_char = (!display_on || view >= CELLS) ? SPACE_CHAR : cell_text[view];
      return res;
   endfunction

   task automatic compare_field(input string name, input logic signed [9:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      lcd_result_type exp;
      if (reset) begin
         blank_cells();
         cursor_pos    = 0;
         display_on    = 1'b1;
         count_up_mode = 1'b1;
         prior_enable  = LEVEL_UNDEF;
         expected_rsp.delete();
         fail_count    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no request waiting");
               fail_count++;
            end else begin
               exp = expected_rsp.pop_front();
               compare_field("status", exp.status, rsp_status);
               compare_field("action", exp.action, rsp_action);
               compare_field("cursor", $signed(exp.cursor), rsp_cursor);
               compare_field("shown", exp.shown, rsp_shown);
               compare_field("count_up", exp.count_up, rsp_count_up);
               compare_field("view_char", exp.view_char, rsp_view_char);
            end
         end
         if (req_valid && req_ready) begin
            expected_rsp.push_back(lcd_step(req_enable_level, req_select_level,
                                            req_direction_level, req_bus_byte,
                                            req_bus_defined, req_view_index));
         end
      end
      outstanding = expected_rsp.size();
   end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the character LCD controller. A short directed
// pass hits each status and the clear, set-address, display, entry and unused
// commands, then random pin samples, mostly clean enable edges, plus two long
// cursor walks into both saturation limits.
module tb_top
   import clcd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam level_type  LEVEL_BAD  = 2'd3;
   localparam logic [7:0] CMD_UNUSED = 8'h00;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_enable_level;
   logic [1:0]        req_select_level;
   logic [1:0]        req_direction_level;
   logic [7:0]        req_bus_byte;
   logic              req_bus_defined;
   logic [4:0]        req_view_index;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [2:0]        rsp_status;
   logic [1:0]        rsp_action;
   logic signed [8:0] rsp_cursor;
   logic              rsp_shown;
   logic              rsp_count_up;
   logic [7:0]        rsp_view_char;
   int                fail_count;
   int                outstanding;

   int                items_sent;
   bit                tx_steady;

   character_lcd_controller #(.COLUMNS(16)) DUT (.*);

   character_lcd_checker #(.COLUMNS(16)) lcd_check (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5ms;
      $display("FAIL character_lcd_controller");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic level_type any_level();
      return level_type'($urandom_range(0, 3));
   endfunction

   function automatic logic [7:0] pick_command();
      int         r;
      logic [7:0] addr;
      r = $urandom_range(0, 99);
      addr = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                  : 8'(ROW_TWO_BASE) + 8'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) addr = 8'($urandom_range(0, 127));
      if (r < 8)  return CMD_CLEAR;
      if (r < 16) return CMD_HOME;
      if (r < 50) return CMD_SET_ADDR | addr;
      if (r < 70) begin
         return CMD_DISPLAY | ($urandom_range(0, 3) ? DISP_ON_BIT : 8'h00)
                | 8'($urandom_range(0, 3));
      end
      if (r < 85) return CMD_ENTRY | 8'($urandom_range(0, 3));
      return 8'($urandom);
   endfunction

   // hold the request until it is taken
   task automatic push_sample(input level_type en, rs, rw, input logic [7:0] data,
                              input logic defined, input logic [4:0] view);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_enable_level    <= en;
      req_select_level    <= rs;
      req_direction_level <= rw;
      req_bus_byte        <= data;
      req_bus_defined     <= defined;
      req_view_index      <= view;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // low sample with junk on the other pins, then the high sample that acts
   task automatic push_edge(input level_type rs, rw, input logic [7:0] data,
                            input logic defined, input logic [4:0] view);
      push_sample(LEVEL_LOW, any_level(), any_level(), 8'($urandom),
                  1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
      push_sample(LEVEL_HIGH, rs, rw, data, defined, view);
   endtask

   task automatic push_noise();
      case ($urandom_range(0, 4))
         0: push_sample(any_level(), any_level(), any_level(), 8'($urandom),
                        1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
         1: push_edge($urandom_range(0, 1) ? LEVEL_UNDEF : LEVEL_BAD, any_level(),
                      8'($urandom), 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
         2: push_edge(any_level(), $urandom_range(0, 1) ? LEVEL_UNDEF : LEVEL_BAD,
                      8'($urandom), 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
         3: push_edge(level_type'($urandom_range(0, 1)), LEVEL_HIGH, 8'($urandom),
                      1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
         default: push_edge(level_type'($urandom_range(0, 1)), LEVEL_LOW, 8'($urandom),
                            1'b0, 5'($urandom_range(0, 31)));
      endcase
   endtask

   task automatic run_mix(input int count);
      int target;
      int r;
      target = items_sent + count;
      tx_steady = ($urandom_range(0, 3) == 0);
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            push_edge(LEVEL_HIGH, LEVEL_LOW, 8'($urandom), 1'b1,
                      5'($urandom_range(0, 31)));
         end else if (r < 72) begin
            push_edge(LEVEL_LOW, LEVEL_LOW, pick_command(), 1'b1,
                      5'($urandom_range(0, 31)));
         end else begin
            push_noise();
         end
      end
   endtask

   // drive the cursor into a saturation limit with random characters
   task automatic walk_cursor(input bit up);
      tx_steady = 1'($urandom_range(0, 1));
      push_edge(LEVEL_LOW, LEVEL_LOW, up ? (CMD_SET_ADDR | ADDR_MASK) : CMD_HOME, 1'b1,
                5'($urandom_range(0, 31)));
      push_edge(LEVEL_LOW, LEVEL_LOW, CMD_ENTRY | (up ? ENTRY_INC_BIT : 8'h00), 1'b1,
                5'($urandom_range(0, 31)));
      push_edge(LEVEL_LOW, LEVEL_LOW, CMD_DISPLAY | DISP_ON_BIT, 1'b1,
                5'($urandom_range(0, 31)));
      repeat (132) begin
         // held-high or undefined enable never makes an edge
         if ($urandom_range(0, 9) == 0) begin
            push_sample($urandom_range(0, 1) ? LEVEL_HIGH : LEVEL_BAD, any_level(),
                        any_level(), 8'($urandom), 1'($urandom_range(0, 1)),
                        5'($urandom_range(0, 31)));
         end
         push_edge(LEVEL_HIGH, LEVEL_LOW, 8'($urandom), 1'b1, 5'($urandom_range(0, 31)));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
   endtask

   initial begin
      int run;
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         run = $urandom_range(1, 24);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_enable_level    = LEVEL_LOW;
      req_select_level    = LEVEL_LOW;
      req_direction_level = LEVEL_LOW;
      req_bus_byte        = 8'h00;
      req_bus_defined     = 1'b0;
      req_view_index      = 5'd0;
      items_sent          = 0;
      tx_steady           = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset state, first write, held-high and undefined enable
      push_sample(LEVEL_LOW, LEVEL_LOW, LEVEL_LOW, 8'h00, 1'b1, 5'd0);
      push_sample(LEVEL_HIGH, LEVEL_HIGH, LEVEL_LOW, 8'hFF, 1'b1, 5'd0);
      push_sample(LEVEL_HIGH, LEVEL_HIGH, LEVEL_LOW, 8'h41, 1'b1, 5'd31);
      push_sample(LEVEL_BAD, LEVEL_HIGH, LEVEL_LOW, 8'h41, 1'b1, 5'd0);
      push_sample(LEVEL_HIGH, LEVEL_HIGH, LEVEL_LOW, 8'h41, 1'b1, 5'd0);
      // rejected edges
      push_edge(LEVEL_UNDEF, LEVEL_LOW, 8'h41, 1'b1, 5'd0);
      push_edge(LEVEL_HIGH, LEVEL_HIGH, 8'h41, 1'b1, 5'd0);
      push_edge(LEVEL_LOW, LEVEL_BAD, 8'h41, 1'b1, 5'd0);
      push_edge(LEVEL_HIGH, LEVEL_LOW, 8'h42, 1'b0, 5'd1);
      // row two, display toggle, entry mode, unknown byte, clear
      push_edge(LEVEL_LOW, LEVEL_LOW, CMD_SET_ADDR | 8'(ROW_TWO_BASE), 1'b1, 5'd16);
      push_edge(LEVEL_HIGH, LEVEL_LOW, 8'h00, 1'b1, 5'd16);
      push_edge(LEVEL_LOW, LEVEL_LOW, CMD_DISPLAY, 1'b1, 5'd16);
      push_edge(LEVEL_LOW, LEVEL_LOW, CMD_DISPLAY | DISP_ON_BIT, 1'b1, 5'd16);
      push_edge(LEVEL_LOW, LEVEL_LOW, CMD_UNUSED, 1'b1, 5'd0);
      push_edge(LEVEL_LOW, LEVEL_LOW, CMD_ENTRY, 1'b1, 5'd0);
      push_edge(LEVEL_LOW, LEVEL_LOW, CMD_CLEAR, 1'b1, 5'd0);
      push_edge(LEVEL_LOW, LEVEL_LOW, CMD_ENTRY | ENTRY_INC_BIT, 1'b1, 5'd16);
      drain();

      run_mix(20);
      walk_cursor(1'b1);
      run_mix(20);
      drain();
      walk_cursor(1'b0);
      run_mix(20);

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS character_lcd_controller");
      end else begin
         $display("FAIL character_lcd_controller");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/clcd_pkg.sv
sv/character_lcd_controller.sv
test/character_lcd_checker.sv
test/tb_top.sv
